// File: src/tlbrr_pkg.sv
// ----------------------------------------------------------------------------
// tlbrr_pkg
// shared constants and types for the round-robin refill translation buffer
// ----------------------------------------------------------------------------
package tlbrr_pkg;

  localparam int TLB_ENTRIES_DEF = 64;

  // width of one leaf group of the lowest-set-bit finder
  localparam int FIND_GROUP = 16;

  localparam int SLOT_W = 6;
  localparam int PAGE_W = 20;
  localparam int WORD_W = 32;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_INV_ALL = 2'd1;
  localparam logic [1:0] REQ_INV_ONE = 2'd2;

  localparam logic [2:0] OUT_FREE        = 3'd0;
  localparam logic [2:0] OUT_HIT         = 3'd1;
  localparam logic [2:0] OUT_VICTIM      = 3'd2;
  localparam logic [2:0] OUT_ALL_CLEARED = 3'd3;
  localparam logic [2:0] OUT_ONE_CLEARED = 3'd4;
  localparam logic [2:0] OUT_ABSENT      = 3'd5;

  localparam logic [WORD_W-1:0] LO_VALID_MASK = 32'h0000_0200;
  localparam logic [WORD_W-1:0] LO_DIRTY_MASK = 32'h0000_0400;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // transaction accepted, capture request and match vectors
    logic group;   // finder leaf stage
    logic select;  // finder root stage
    logic update;  // write state and present the result
  } tlbrr_cmd_t;

endpackage

// File: src/tlbrr_find.sv
// ----------------------------------------------------------------------------
// tlbrr_find
// two-stage registered finder of the lowest set bit in a vector
// ----------------------------------------------------------------------------
module tlbrr_find #(
  parameter int N = tlbrr_pkg::TLB_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic [N-1:0]         vec,
  input  logic                 step_group,
  input  logic                 step_select,
  output logic                 found,
  output logic [$clog2(N)-1:0] idx
);
  import tlbrr_pkg::*;

  localparam int IW  = $clog2(N);
  localparam int G   = FIND_GROUP;
  localparam int GW  = $clog2(G);
  localparam int NG  = (N + G - 1) / G;
  localparam int NGW = (NG > 1) ? $clog2(NG) : 1;
  localparam int IFW = NGW + GW;

  logic [NG*G-1:0]         vec_pad;
  logic [NG-1:0]           any_c;
  logic [NG-1:0][GW-1:0]   idx_c;
  logic [NG-1:0]           grp_any;
  logic [NG-1:0][GW-1:0]   grp_idx;
  logic [NGW-1:0]          sel_c;
  logic [IFW-1:0]          full_c;

  always_comb begin
    vec_pad = '0;
    vec_pad[N-1:0] = vec;
  end

  // leaf stage: lowest set bit inside each group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      any_c[g] = |vec_pad[g*G +: G];
      idx_c[g] = '0;
      for (int b = G - 1; b >= 0; b--) begin
        if (vec_pad[g*G + b]) begin
          idx_c[g] = GW'(b);
        end
      end
    end
  end

  // root stage: lowest group with a set bit
  always_comb begin
    sel_c = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        sel_c = NGW'(g);
      end
    end
    full_c = (IFW'(sel_c) << GW) | IFW'(grp_idx[sel_c]);
  end

  always_ff @(posedge clk) begin
    if (step_group) begin
      grp_any <= any_c;
      grp_idx <= idx_c;
    end
    if (step_select) begin
      found <= |grp_any;
      idx   <= full_c[IW-1:0];
    end
  end

endmodule

// File: src/tlbrr_ctrl.sv
// ----------------------------------------------------------------------------
// tlbrr_ctrl
// sequencer for one request: capture, finder leaf, finder root, update
// ----------------------------------------------------------------------------
module tlbrr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  output tlbrr_pkg::tlbrr_cmd_t  cmd
);
  import tlbrr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GROUP,
    S_SELECT,
    S_UPDATE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    unique case (state)
      S_IDLE:   state_next = start ? S_GROUP : S_IDLE;
      S_GROUP:  state_next = S_SELECT;
      S_SELECT: state_next = S_UPDATE;
      S_UPDATE: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.load   = start && (state == S_IDLE);
    cmd.group  = (state == S_GROUP);
    cmd.select = (state == S_SELECT);
    cmd.update = (state == S_UPDATE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// File: src/tlbrr_dp.sv
// ----------------------------------------------------------------------------
// tlbrr_dp
// tag and valid arrays, match and free finders, victim pointer, result regs
// ----------------------------------------------------------------------------
module tlbrr_dp #(
  parameter int TLB_ENTRIES = tlbrr_pkg::TLB_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tlbrr_pkg::tlbrr_cmd_t  cmd,
  input  logic [1:0]             req_type,
  input  logic [19:0]            virtual_page,
  input  logic [31:0]            low_word,
  input  logic                   writable,
  output logic                   done,
  output logic [5:0]             slot,
  output logic [2:0]             outcome,
  output logic [31:0]            written_low
);
  import tlbrr_pkg::*;

  localparam int N  = TLB_ENTRIES;
  localparam int IW = $clog2(N);

  logic [PAGE_W-1:0] tags [N];
  logic [N-1:0]      valid;
  logic [IW-1:0]     victim;

  logic [1:0]        req_q;
  logic [PAGE_W-1:0] page_q;
  logic [WORD_W-1:0] word_q;
  logic              wr_q;
  logic [N-1:0]      hit_vec;
  logic [N-1:0]      free_vec;

  logic              hit_found;
  logic [IW-1:0]     hit_idx;
  logic              free_found;
  logic [IW-1:0]     free_idx;

  logic [IW-1:0]     target_c;
  logic [IW+5:0]     slot_ext;
  logic [WORD_W-1:0] new_word_c;

  // per-slot comparators against the incoming page
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= req_type;
      page_q <= virtual_page;
      word_q <= low_word;
      wr_q   <= writable;
      for (int s = 0; s < N; s++) begin
        hit_vec[s] <= valid[s] && (tags[s] == virtual_page);
      end
      free_vec <= ~valid;
    end
  end

  tlbrr_find #(.N(N)) u_hit_find (
    .clk         (clk),
    .vec         (hit_vec),
    .step_group  (cmd.group),
    .step_select (cmd.select),
    .found       (hit_found),
    .idx         (hit_idx)
  );

  tlbrr_find #(.N(N)) u_free_find (
    .clk         (clk),
    .vec         (free_vec),
    .step_group  (cmd.group),
    .step_select (cmd.select),
    .found       (free_found),
    .idx         (free_idx)
  );

  always_comb begin
    priority if (hit_found) begin
      target_c = hit_idx;
    end else if (free_found) begin
      target_c = free_idx;
    end else begin
      target_c = victim;
    end
    new_word_c = word_q | LO_VALID_MASK | (wr_q ? LO_DIRTY_MASK : '0);
  end

  // slot number as reported: low six bits, zero extended for small buffers
  always_comb begin
    priority if (req_q == REQ_LOAD) begin
      slot_ext = (IW + 6)'(target_c);
    end else begin
      slot_ext = (IW + 6)'(hit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && (req_q == REQ_LOAD)) begin
      tags[target_c] <= page_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      victim <= '0;
      done   <= 1'b0;
    end else begin
      done <= cmd.update;
      if (cmd.update) begin
        unique case (req_q)
          REQ_LOAD: begin
            valid[target_c] <= 1'b1;
            if (!hit_found && !free_found) begin
              victim <= (victim == IW'(N - 1)) ? '0 : victim + 1'b1;
            end
          end
          REQ_INV_ALL: begin
            valid <= '0;
          end
          REQ_INV_ONE: begin
            if (hit_found) begin
              valid[hit_idx] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      unique case (req_q)
        REQ_LOAD: begin
          slot        <= slot_ext[5:0];
          written_low <= new_word_c;
          priority if (hit_found) begin
            outcome <= OUT_HIT;
          end else if (free_found) begin
            outcome <= OUT_FREE;
          end else begin
            outcome <= OUT_VICTIM;
          end
        end
        REQ_INV_ALL: begin
          slot        <= '0;
          outcome     <= OUT_ALL_CLEARED;
          written_low <= '0;
        end
        REQ_INV_ONE: begin
          slot        <= hit_found ? slot_ext[5:0] : '0;
          outcome     <= hit_found ? OUT_ONE_CLEARED : OUT_ABSENT;
          written_low <= '0;
        end
        default: begin
          slot        <= '0;
          outcome     <= OUT_ABSENT;
          written_low <= '0;
        end
      endcase
    end
  end

endmodule

// File: src/tlb_fill_round_robin.sv
// ----------------------------------------------------------------------------
// tlb_fill_round_robin
// fully associative translation buffer with round-robin refill
//
//   channel   handshake        payload
//   request   start / busy     req_type, virtual_page, low_word, writable
//   result    done (1 cycle)   slot, outcome, written_low
//
// a request passes through the parallel tag compare, the leaf and root stages of
// the registered lowest-slot finder and the state update before the next request
// is accepted; done is high in the cycle after the update.
// synchronous reset marks every slot invalid and zeroes the victim pointer
// at once, so no clearing pass is needed. the receiver cannot stall: each
// result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module tlb_fill_round_robin #(
  parameter int TLB_ENTRIES = tlbrr_pkg::TLB_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [19:0] virtual_page,
  input  logic [31:0] low_word,
  input  logic        writable,
  output logic        done,
  output logic [5:0]  slot,
  output logic [2:0]  outcome,
  output logic [31:0] written_low
);
  import tlbrr_pkg::*;

  tlbrr_cmd_t cmd;

  tlbrr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  tlbrr_dp #(.TLB_ENTRIES(TLB_ENTRIES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_type     (req_type),
    .virtual_page (virtual_page),
    .low_word     (low_word),
    .writable     (writable),
    .done         (done),
    .slot         (slot),
    .outcome      (outcome),
    .written_low  (written_low)
  );

`ifndef NO_ASSERTIONS
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("result did not follow an accepted transaction");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a transaction is in progress");

  a_inval_zero_word: assert property (@(posedge clk) disable iff (rst)
    (done && (outcome == OUT_ALL_CLEARED || outcome == OUT_ONE_CLEARED ||
              outcome == OUT_ABSENT)) |-> (written_low == '0))
    else $error("invalidation reported a nonzero low word");

  a_load_valid_bit: assert property (@(posedge clk) disable iff (rst)
    (done && (outcome == OUT_FREE || outcome == OUT_HIT ||
              outcome == OUT_VICTIM)) |-> ((written_low & LO_VALID_MASK) != '0))
    else $error("load result without the valid bit");
`endif

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the round-robin refill translation buffer against a cycle-free
// model of its slots, tags and victim pointer: loads that hit, take a free
// slot or evict the round-robin victim, single and global invalidations,
// and the unused request code, with random idle cycles on the request side
// ----------------------------------------------------------------------------
module testbench;
  import tlbrr_pkg::*;

  localparam int N_SLOTS = TLB_ENTRIES_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_PCT = 29;
  localparam int RANDOM_ITEMS = 1000;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 16;

  typedef struct {
    logic [1:0]  kind;
    logic [19:0] page;
    logic [31:0] word;
    logic        wr;
    bit          drain_first;  // hold off until every result is back
  } tlb_req_t;

  typedef struct {
    logic [5:0]  slot;
    logic [2:0]  outcome;
    logic [31:0] written_low;
  } refill_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = '0;
  logic [19:0] virtual_page = '0;
  logic [31:0] low_word = '0;
  logic        writable = 1'b0;
  logic        done;
  logic [5:0]  slot;
  logic [2:0]  outcome;
  logic [31:0] written_low;

  tlb_fill_round_robin #(
    .TLB_ENTRIES(N_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .virtual_page(virtual_page),
    .low_word(low_word),
    .writable(writable),
    .done(done),
    .slot(slot),
    .outcome(outcome),
    .written_low(written_low)
  );

  // model state
  logic [19:0] tag_mem [N_SLOTS];
  logic [31:0] word_mem [N_SLOTS];
  int          victim_ptr;

  tlb_req_t pending_q [$];
  refill_t  refill_q [$];
  tlb_req_t cur_req;
  int n_accepted = 0;
  int n_results = 0;
  int n_issued = 0;
  int n_errors = 0;
  int stall_cycles = 0;
  int outcome_seen [8];

  function automatic refill_t predict_refill(input tlb_req_t rq);
    refill_t r;
    int hit_at;
    int free_at;
    int target;
    logic [31:0] w;
    r.slot = '0;
    r.outcome = OUT_ABSENT;
    r.written_low = '0;
    hit_at = -1;
    free_at = -1;
    // walk downward so the lowest match and lowest free slot win
    for (int s = N_SLOTS - 1; s >= 0; s--) begin
      if ((word_mem[s] & LO_VALID_MASK) != 0) begin
        if (tag_mem[s] == rq.page) hit_at = s;
      end else begin
        free_at = s;
      end
    end
    case (rq.kind)
      REQ_LOAD: begin
        if (hit_at >= 0) begin
          target = hit_at;
          r.outcome = OUT_HIT;
        end else if (free_at >= 0) begin
          target = free_at;
          r.outcome = OUT_FREE;
        end else begin
          target = victim_ptr;
          victim_ptr = (victim_ptr + 1) % N_SLOTS;
          r.outcome = OUT_VICTIM;
        end
        w = rq.word | LO_VALID_MASK;
        if (rq.wr) w = w | LO_DIRTY_MASK;
        tag_mem[target] = rq.page;
        word_mem[target] = w;
        r.slot = SLOT_W'(target);
        r.written_low = w;
      end
      REQ_INV_ALL: begin
        for (int s = 0; s < N_SLOTS; s++) begin
          tag_mem[s] = '0;
          word_mem[s] = '0;
        end
        r.outcome = OUT_ALL_CLEARED;
      end
      REQ_INV_ONE: begin
        if (hit_at >= 0) begin
          tag_mem[hit_at] = '0;
          word_mem[hit_at] = '0;
          r.slot = SLOT_W'(hit_at);
          r.outcome = OUT_ONE_CLEARED;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic add_req(input logic [1:0] kind, input logic [19:0] page,
                         input logic [31:0] word, input logic wr, input bit drain);
    tlb_req_t rq;
    rq.kind = kind;
    rq.page = page;
    rq.word = word;
    rq.wr = wr;
    rq.drain_first = drain;
    pending_q.push_back(rq);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // driver: one transaction in flight at most, start held until accepted
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        refill_q.push_back(predict_refill(cur_req));
        n_accepted++;
      end
      if (!start || !busy) begin
        if (pending_q.size() != 0
            && !(pending_q[0].drain_first && n_accepted != n_results)
            && !((n_issued < 400 || n_issued >= 600)
                 && $urandom_range(0, 99) < IDLE_PCT)) begin
          cur_req = pending_q.pop_front();
          n_issued++;
          start <= 1'b1;
          req_type <= cur_req.kind;
          virtual_page <= cur_req.page;
          low_word <= cur_req.word;
          writable <= cur_req.wr;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be held off, so check every strobe
  always @(posedge clk) begin
    refill_t exp_r;
    if (!rst && done) begin
      n_results <= n_results + 1;
      if (refill_q.size() == 0) begin
        $error("result with nothing expected: slot %0d outcome %0d", slot, outcome);
        n_errors++;
      end else begin
        exp_r = refill_q.pop_front();
        outcome_seen[exp_r.outcome]++;
        if (slot !== exp_r.slot) begin
          $error("slot mismatch: expected %0d, got %0d", exp_r.slot, slot);
          n_errors++;
        end
        if (outcome !== exp_r.outcome) begin
          $error("outcome mismatch: expected %0d, got %0d", exp_r.outcome, outcome);
          n_errors++;
        end
        if (written_low !== exp_r.written_low) begin
          $error("written_low mismatch: expected %h, got %h",
                 exp_r.written_low, written_low);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[tlb_fill_round_robin] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [19:0] page_pool [128];
    int pool_sizes [4];
    int n_random;
    int seg_len;
    int psize;
    int r;
    logic [19:0] pg;

    for (int s = 0; s < N_SLOTS; s++) begin
      tag_mem[s] = '0;
      word_mem[s] = '0;
    end
    victim_ptr = 0;
    for (int k = 0; k < 8; k++) outcome_seen[k] = 0;

    // directed: extreme fields, every request kind, tag zero on empty slots
    add_req(REQ_INV_ONE, 20'h00000, 32'h0000_0000, 1'b0, 1'b0);
    add_req(REQ_LOAD,    20'h00000, 32'h0000_0000, 1'b0, 1'b0);
    add_req(REQ_LOAD,    20'hFFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_req(REQ_LOAD,    20'h00000, 32'hA5A5_5A5A, 1'b1, 1'b0);
    add_req(REQ_INV_ONE, 20'h54321, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_req(REQ_UNUSED,  20'hFFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_req(REQ_INV_ONE, 20'hFFFFF, 32'h0000_0000, 1'b0, 1'b0);
    add_req(REQ_LOAD,    20'h12345, 32'h0000_0600, 1'b0, 1'b0);
    add_req(REQ_LOAD,    20'hABCDE, 32'hFFFF_F9FF, 1'b1, 1'b0);
    add_req(REQ_INV_ONE, 20'h00000, 32'h0000_0000, 1'b0, 1'b0);
    add_req(REQ_LOAD,    20'hFFFFF, 32'h8000_0001, 1'b0, 1'b0);
    add_req(REQ_INV_ALL, 20'hFFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_req(REQ_INV_ONE, 20'h12345, 32'h0000_0000, 1'b0, 1'b0);
    add_req(REQ_LOAD,    20'h00001, 32'h0000_0000, 1'b0, 1'b0);
    add_req(REQ_UNUSED,  20'h00000, 32'h0000_0000, 1'b0, 1'b0);

    // random: segments over a page pool, the larger pools overflow the
    // buffer and drive the round-robin victim through its wrap
    page_pool[0] = 20'h00000;
    page_pool[1] = 20'hFFFFF;
    for (int k = 2; k < 128; k++) page_pool[k] = 20'($urandom);
    pool_sizes = '{12, 48, 80, 128};
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      psize = pool_sizes[$urandom_range(0, 3)];
      seg_len = $urandom_range(40, 200);
      if ($urandom_range(0, 1) == 1) begin
        add_req(REQ_INV_ALL, 20'($urandom), $urandom, 1'($urandom), n_random == 0);
        n_random++;
      end
      for (int k = 0; k < seg_len; k++) begin
        r = $urandom_range(0, 99);
        pg = ($urandom_range(0, 99) < 90) ? page_pool[$urandom_range(0, psize - 1)]
                                          : 20'($urandom);
        if (r < 72)
          add_req(REQ_LOAD, pg, $urandom, 1'($urandom),
                  n_random == 0 || $urandom_range(0, 99) == 0);
        else if (r < 90)
          add_req(REQ_INV_ONE, pg, $urandom, 1'($urandom), n_random == 0);
        else if (r < 95)
          add_req(REQ_UNUSED, pg, $urandom, 1'($urandom), n_random == 0);
        else if (r < 97)
          add_req(REQ_INV_ALL, pg, $urandom, 1'($urandom), n_random == 0);
        else
          add_req(REQ_LOAD, 20'($urandom), $urandom, 1'($urandom), n_random == 0);
        n_random++;
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending_q.size() != 0 || start || n_results != n_accepted) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (refill_q.size() != 0) begin
      $error("%0d expected results never arrived", refill_q.size());
      n_errors++;
    end

    $display("ran %0d requests: %0d free-slot loads, %0d hits, %0d victim evictions,",
             n_accepted, outcome_seen[OUT_FREE], outcome_seen[OUT_HIT],
             outcome_seen[OUT_VICTIM]);
    $display("%0d global clears, %0d single clears, %0d absent or unused requests",
             outcome_seen[OUT_ALL_CLEARED], outcome_seen[OUT_ONE_CLEARED],
             outcome_seen[OUT_ABSENT]);
    if (n_errors == 0) begin
      $display("[tlb_fill_round_robin] OK");
    end else begin
      $display("[tlb_fill_round_robin] ERROR");
    end
    $finish;
  end

endmodule
